// File: rtl/rawf_pkg.sv
package rawf_pkg;

    localparam int DATA_W       = 32;
    localparam int HALF_W       = 16;
    localparam int FIELD_IDX_W  = 3;
    localparam int KIND_W       = 5;
    localparam int SHAMT_W      = 5;
    localparam int OUT_REGS     = 8;
    localparam int NUM_REGS_DEF = 8;

    localparam logic [DATA_W-1:0] HALF_MASK = 32'h0000_FFFF;

    // instruction codes
    localparam logic [KIND_W-1:0] K_MOV  = 5'd0;
    localparam logic [KIND_W-1:0] K_ADD  = 5'd1;
    localparam logic [KIND_W-1:0] K_ADDS = 5'd2;
    localparam logic [KIND_W-1:0] K_SUB  = 5'd3;
    localparam logic [KIND_W-1:0] K_SUBS = 5'd4;
    localparam logic [KIND_W-1:0] K_AND  = 5'd5;
    localparam logic [KIND_W-1:0] K_ANDS = 5'd6;
    localparam logic [KIND_W-1:0] K_ORR  = 5'd7;
    localparam logic [KIND_W-1:0] K_ORRS = 5'd8;
    localparam logic [KIND_W-1:0] K_XOR  = 5'd9;
    localparam logic [KIND_W-1:0] K_XORS = 5'd10;
    localparam logic [KIND_W-1:0] K_CMP  = 5'd11;
    localparam logic [KIND_W-1:0] K_TST  = 5'd12;
    localparam logic [KIND_W-1:0] K_LSR  = 5'd13;
    localparam logic [KIND_W-1:0] K_LSRS = 5'd14;
    localparam logic [KIND_W-1:0] K_LSL  = 5'd15;
    localparam logic [KIND_W-1:0] K_LSLS = 5'd16;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [FIELD_IDX_W-1:0] dest_reg;
        logic [FIELD_IDX_W-1:0] src_a;
        logic [FIELD_IDX_W-1:0] src_b;
        logic [DATA_W-1:0]      immediate;
        logic [SHAMT_W-1:0]     shift_amount;
    } t_in_item;

    // ALU outcome handed back to the register file
    typedef struct packed {
        logic              wr_en;
        logic [DATA_W-1:0] wr_data;
        t_flags            flags;
    } t_alu_res;

endpackage

// File: rtl/rawf_if.sv
interface rawf_in_if;
    import rawf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [FIELD_IDX_W-1:0] dest_reg;
    logic [FIELD_IDX_W-1:0] src_a;
    logic [FIELD_IDX_W-1:0] src_b;
    logic [DATA_W-1:0]      immediate;
    logic [SHAMT_W-1:0]     shift_amount;

    modport source (
        output valid, kind, dest_reg, src_a, src_b, immediate, shift_amount,
        input  ready
    );
    modport sink (
        input  valid, kind, dest_reg, src_a, src_b, immediate, shift_amount,
        output ready
    );
endinterface

interface rawf_out_if;
    import rawf_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] reg0;
    logic [DATA_W-1:0] reg1;
    logic [DATA_W-1:0] reg2;
    logic [DATA_W-1:0] reg3;
    logic [DATA_W-1:0] reg4;
    logic [DATA_W-1:0] reg5;
    logic [DATA_W-1:0] reg6;
    logic [DATA_W-1:0] reg7;
    logic              flag_n;
    logic              flag_z;
    logic              flag_c;
    logic              flag_v;

    modport source (
        output valid, reg0, reg1, reg2, reg3, reg4, reg5, reg6, reg7,
               flag_n, flag_z, flag_c, flag_v,
        input  ready
    );
    modport sink (
        input  valid, reg0, reg1, reg2, reg3, reg4, reg5, reg6, reg7,
               flag_n, flag_z, flag_c, flag_v,
        output ready
    );
endinterface

// File: rtl/register_alu_with_flags.sv
// Register ALU with NZCV flags.
// The accepted input beat is staged in the input register, then executes into the result register.
// Throughput: one instruction per cycle while the result beat is taken; the register
// file and flags are read, updated and written back as the instruction executes.
// Reset (synchronous, active low): registers and flags clear to zero, both
// pipeline valids drop.
module register_alu_with_flags #(
    parameter int NUM_REGS = rawf_pkg::NUM_REGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rawf_in_if.sink     i_in,
    rawf_out_if.source  o_out
);
    import rawf_pkg::*;

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_regs [OUT_REGS];
    t_flags            r_out_flags;
    logic [DATA_W-1:0] r_regs [NUM_REGS];
    t_flags            r_flags;
    logic [DATA_W-1:0] n_regs [NUM_REGS];

    logic              adv;
    logic [DATA_W-1:0] vd;
    logic [DATA_W-1:0] va;
    logic [DATA_W-1:0] vb;
    t_alu_res          alu_res;
    logic [IDX_W-1:0]  dest_sel;
    logic              dest_ok;

    // execute when an item is staged and the result register can take it
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in.kind         <= i_in.kind;
            r_in.dest_reg     <= i_in.dest_reg;
            r_in.src_a        <= i_in.src_a;
            r_in.src_b        <= i_in.src_b;
            r_in.immediate    <= i_in.immediate;
            r_in.shift_amount <= i_in.shift_amount;
        end
    end

    // operand reads; indices past the file read as zero
    function automatic logic [DATA_W-1:0] rd_reg(
        input logic [FIELD_IDX_W-1:0] idx,
        input logic [DATA_W-1:0]      regs [NUM_REGS]
    );
        logic [IDX_W-1:0] sel;
        sel = IDX_W'(idx);
        if (int'(idx) < NUM_REGS) return regs[sel];
        return '0;
    endfunction

    assign vd = rd_reg(r_in.dest_reg, r_regs);
    assign va = rd_reg(r_in.src_a, r_regs);
    assign vb = rd_reg(r_in.src_b, r_regs);

    rawf_alu u_alu (
        .i_item  (r_in),
        .i_vd    (vd),
        .i_va    (va),
        .i_vb    (vb),
        .i_flags (r_flags),
        .o_res   (alu_res)
    );

    // write-back; writes past the file are dropped
    assign dest_sel = IDX_W'(r_in.dest_reg);
    assign dest_ok  = int'(r_in.dest_reg) < NUM_REGS;

    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            n_regs[i] = r_regs[i];
        end
        if (alu_res.wr_en && dest_ok) begin
            n_regs[dest_sel] = alu_res.wr_data;
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_flags <= '0;
        end else if (adv) begin
            r_regs  <= n_regs;
            r_flags <= alu_res.flags;
        end
    end

    // result register: snapshot of the state after the instruction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out_flags <= alu_res.flags;
        end
    end

    for (genvar g = 0; g < OUT_REGS; g++) begin : g_out
        if (g < NUM_REGS) begin : g_live
            always_ff @(posedge i_clk) begin
                if (adv) r_out_regs[g] <= n_regs[g];
            end
        end else begin : g_absent
            always_ff @(posedge i_clk) begin
                r_out_regs[g] <= '0;
            end
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.reg0   = r_out_regs[0];
    assign o_out.reg1   = r_out_regs[1];
    assign o_out.reg2   = r_out_regs[2];
    assign o_out.reg3   = r_out_regs[3];
    assign o_out.reg4   = r_out_regs[4];
    assign o_out.reg5   = r_out_regs[5];
    assign o_out.reg6   = r_out_regs[6];
    assign o_out.reg7   = r_out_regs[7];
    assign o_out.flag_n = r_out_flags.n;
    assign o_out.flag_z = r_out_flags.z;
    assign o_out.flag_c = r_out_flags.c;
    assign o_out.flag_v = r_out_flags.v;

endmodule

// File: rtl/rawf_alu.sv
module rawf_alu (
    input  rawf_pkg::t_in_item              i_item,
    input  logic [rawf_pkg::DATA_W-1:0]     i_vd,
    input  logic [rawf_pkg::DATA_W-1:0]     i_va,
    input  logic [rawf_pkg::DATA_W-1:0]     i_vb,
    input  rawf_pkg::t_flags                i_flags,
    output rawf_pkg::t_alu_res              o_res
);
    import rawf_pkg::*;

    logic [DATA_W:0]   sum_w;
    logic [DATA_W:0]   diff_w;
    logic [DATA_W-1:0] sum_lo;
    logic [DATA_W-1:0] diff_lo;
    logic [DATA_W-1:0] and_v;
    logic [DATA_W-1:0] orr_v;
    logic [DATA_W-1:0] xor_v;
    logic [DATA_W-1:0] lsr_v;
    logic [DATA_W-1:0] lsl_v;
    t_flags            add_f;
    t_flags            sub_f;

    // shared arithmetic; N and Z of add/sub come from the 16-bit masked value
    always_comb begin
        sum_w   = {1'b0, i_va} + {1'b0, i_vb};
        diff_w  = {1'b0, i_va} - {1'b0, i_vb};
        sum_lo  = sum_w[DATA_W-1:0] & HALF_MASK;
        diff_lo = diff_w[DATA_W-1:0] & HALF_MASK;
        and_v   = i_vd & i_va;
        orr_v   = i_vd | i_va;
        xor_v   = i_vd ^ i_va;
        lsr_v   = i_va >> i_item.shift_amount;
        lsl_v   = i_va << i_item.shift_amount;

        add_f.n = sum_lo[DATA_W-1];
        add_f.z = (sum_lo == '0);
        add_f.c = sum_w[DATA_W];
        add_f.v = (i_va[DATA_W-1] == i_vb[DATA_W-1])
                  && (i_va[DATA_W-1] != sum_w[DATA_W-1]);

        sub_f.n = diff_lo[DATA_W-1];
        sub_f.z = (diff_lo == '0);
        sub_f.c = ~diff_w[DATA_W];      // no borrow: a >= b unsigned
        sub_f.v = (i_va[DATA_W-1] != i_vb[DATA_W-1])
                  && (i_va[DATA_W-1] != diff_w[DATA_W-1]);
    end

    // per-kind write-back and flag select
    always_comb begin
        o_res.wr_en   = 1'b0;
        o_res.wr_data = '0;
        o_res.flags   = i_flags;
        case (i_item.kind) inside
            K_MOV: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = i_item.immediate;
            end
            K_ADD, K_ADDS: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = sum_lo;
                if (i_item.kind == K_ADDS) o_res.flags = add_f;
            end
            K_SUB, K_SUBS: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = diff_lo;
                if (i_item.kind == K_SUBS) o_res.flags = sub_f;
            end
            K_AND, K_ANDS: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = and_v;
            end
            K_ORR, K_ORRS: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = orr_v;
            end
            K_XOR, K_XORS: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = xor_v;
            end
            K_CMP: begin
                o_res.flags = sub_f;
            end
            K_TST: begin
                o_res.flags.n = and_v[DATA_W-1] & i_vb[DATA_W-1] & i_va[DATA_W-1];
                o_res.flags.z = ((i_va & i_vb) == '0);
            end
            K_LSR, K_LSRS: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = lsr_v;
            end
            K_LSL, K_LSLS: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = lsl_v;
            end
            default: begin
            end
        endcase

        // logical and shift S-forms: N and Z from the full value written
        if (i_item.kind == K_ANDS || i_item.kind == K_ORRS || i_item.kind == K_XORS
            || i_item.kind == K_LSRS || i_item.kind == K_LSLS) begin
            o_res.flags.n = o_res.wr_data[DATA_W-1];
            o_res.flags.z = (o_res.wr_data == '0);
        end

        // TST: N is bit 31 of va & vb
        if (i_item.kind == K_TST) begin
            o_res.flags.n = i_va[DATA_W-1] & i_vb[DATA_W-1];
        end
    end

endmodule

// File: tb/register_alu_with_flags_tb.sv
`timescale 1ns / 1ps

module register_alu_with_flags_tb;
    import rawf_pkg::*;

    // codes with no instruction behind them
    localparam logic [KIND_W-1:0] K_FIRST_UNUSED = 5'd17;
    localparam logic [KIND_W-1:0] K_LAST_UNUSED  = 5'd31;

    // register file and flags as seen after one instruction
    typedef struct packed {
        logic [OUT_REGS-1:0][DATA_W-1:0] regs;
        t_flags                          flags;
    } t_arch_snap;

    // instruction waiting to be sent, with its lead-in gap and drain request
    typedef struct packed {
        t_in_item   insn;
        logic [7:0] gap;
        logic       drain;
    } t_pending;

    logic clk;
    logic rst_n;

    rawf_in_if  in_bus ();
    rawf_out_if out_bus ();

    register_alu_with_flags dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // architectural state mirrored by the testbench
    logic [DATA_W-1:0] arch_regs [0:NUM_REGS_DEF-1];
    t_flags            arch_flags;

    t_pending   insn_q [$];
    t_arch_snap snap_q [$];

    int unsigned fail_cnt;
    int unsigned hold_cnt;
    int unsigned stall_left;
    int unsigned cycle_cnt;
    t_pending    next_beat;
    t_arch_snap  got_snap;
    t_arch_snap  want_snap;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // N and Z from a value
    function automatic void update_nz(input logic [DATA_W-1:0] val);
        arch_flags.n = val[DATA_W-1];
        arch_flags.z = (val == '0);
    endfunction

    // execute one instruction on the mirrored state, return the new snapshot
    function automatic t_arch_snap execute_insn(input t_in_item insn);
        logic [DATA_W-1:0] va;
        logic [DATA_W-1:0] vb;
        logic [DATA_W-1:0] vd;
        logic [DATA_W-1:0] wr_val;
        logic [DATA_W:0]   wide;
        logic              wr_en;
        t_arch_snap        snap;
        va     = arch_regs[insn.src_a];
        vb     = arch_regs[insn.src_b];
        vd     = arch_regs[insn.dest_reg];
        wr_en  = 1'b1;
        wr_val = '0;
        case (insn.kind)
            K_MOV: wr_val = insn.immediate;
            K_ADD, K_ADDS: begin
                wide   = {1'b0, va} + {1'b0, vb};
                wr_val = wide[DATA_W-1:0] & HALF_MASK;
                if (insn.kind == K_ADDS) begin
                    // N/Z from the masked sum, C/V from the full-width add
                    update_nz(wr_val);
                    arch_flags.c = wide[DATA_W];
                    arch_flags.v = (va[DATA_W-1] == vb[DATA_W-1]) &&
                                   (wide[DATA_W-1] != va[DATA_W-1]);
                end
            end
            K_SUB, K_SUBS, K_CMP: begin
                wide   = {1'b0, va} - {1'b0, vb};
                wr_val = wide[DATA_W-1:0] & HALF_MASK;
                wr_en  = (insn.kind != K_CMP);
                if (insn.kind != K_SUB) begin
                    update_nz(wr_val);
                    arch_flags.c = (va >= vb);
                    arch_flags.v = (va[DATA_W-1] != vb[DATA_W-1]) &&
                                   (wide[DATA_W-1] != va[DATA_W-1]);
                end
            end
            K_AND, K_ANDS: begin
                wr_val = vd & va;
                if (insn.kind == K_ANDS) update_nz(wr_val);
            end
            K_ORR, K_ORRS: begin
                wr_val = vd | va;
                if (insn.kind == K_ORRS) update_nz(wr_val);
            end
            K_XOR, K_XORS: begin
                wr_val = vd ^ va;
                if (insn.kind == K_XORS) update_nz(wr_val);
            end
            K_TST: begin
                wr_en = 1'b0;
                update_nz(va & vb);
            end
            K_LSR, K_LSRS: begin
                wr_val = va >> insn.shift_amount;
                if (insn.kind == K_LSRS) update_nz(wr_val);
            end
            K_LSL, K_LSLS: begin
                wr_val = va << insn.shift_amount;
                if (insn.kind == K_LSLS) update_nz(wr_val);
            end
            default: wr_en = 1'b0;
        endcase
        if (wr_en) arch_regs[insn.dest_reg] = wr_val;
        for (int i = 0; i < OUT_REGS; i++)
            snap.regs[i] = (i < NUM_REGS_DEF) ? arch_regs[i] : '0;
        snap.flags = arch_flags;
        return snap;
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [DATA_W-1:0] want,
                                          input logic [DATA_W-1:0] got);
        if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_FFFF;
            5: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_insn(input logic [KIND_W-1:0] kind,
                            input int unsigned rd, input int unsigned ra,
                            input int unsigned rb, input logic [DATA_W-1:0] imm,
                            input int unsigned sh, input int unsigned gap,
                            input bit drain);
        t_pending p;
        p.insn.kind         = kind;
        p.insn.dest_reg     = FIELD_IDX_W'(rd);
        p.insn.src_a        = FIELD_IDX_W'(ra);
        p.insn.src_b        = FIELD_IDX_W'(rb);
        p.insn.immediate    = imm;
        p.insn.shift_amount = SHAMT_W'(sh);
        p.gap               = 8'(gap);
        p.drain             = drain;
        insn_q              = {insn_q, p};
    endtask

    // driver: presents the next instruction once the previous beat is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_bus.valid        <= 1'b0;
            in_bus.kind         <= K_MOV;
            in_bus.dest_reg     <= '0;
            in_bus.src_a        <= '0;
            in_bus.src_b        <= '0;
            in_bus.immediate    <= '0;
            in_bus.shift_amount <= '0;
            hold_cnt = 0;
            for (int i = 0; i < NUM_REGS_DEF; i++) arch_regs[i] = '0;
            arch_flags = '0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (insn_q.size() == 0) begin
                in_bus.valid <= 1'b0;
            end else if (hold_cnt < insn_q[0].gap) begin
                hold_cnt++;
                in_bus.valid <= 1'b0;
            end else if (insn_q[0].drain && snap_q.size() != 0) begin
                in_bus.valid <= 1'b0;
            end else begin
                next_beat = insn_q.pop_front();
                hold_cnt  = 0;
                // the beat is held until taken, so predict it now
                snap_q = {snap_q, execute_insn(next_beat.insn)};
                in_bus.valid        <= 1'b1;
                in_bus.kind         <= next_beat.insn.kind;
                in_bus.dest_reg     <= next_beat.insn.dest_reg;
                in_bus.src_a        <= next_beat.insn.src_a;
                in_bus.src_b        <= next_beat.insn.src_b;
                in_bus.immediate    <= next_beat.insn.immediate;
                in_bus.shift_amount <= next_beat.insn.shift_amount;
            end
        end
    end

    // monitor: checks each result beat and stalls the output at random
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got_snap.regs[0] = out_bus.reg0;
                got_snap.regs[1] = out_bus.reg1;
                got_snap.regs[2] = out_bus.reg2;
                got_snap.regs[3] = out_bus.reg3;
                got_snap.regs[4] = out_bus.reg4;
                got_snap.regs[5] = out_bus.reg5;
                got_snap.regs[6] = out_bus.reg6;
                got_snap.regs[7] = out_bus.reg7;
                got_snap.flags   = {out_bus.flag_n, out_bus.flag_z,
                                    out_bus.flag_c, out_bus.flag_v};
                if (snap_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("result beat with nothing expected: %h", got_snap);
                end else begin
                    want_snap = snap_q.pop_front();
                    for (int i = 0; i < OUT_REGS; i++)
                        compare_field($sformatf("reg%0d", i), want_snap.regs[i],
                                      got_snap.regs[i]);
                    compare_field("flag_n", DATA_W'(want_snap.flags.n),
                                  DATA_W'(got_snap.flags.n));
                    compare_field("flag_z", DATA_W'(want_snap.flags.z),
                                  DATA_W'(got_snap.flags.z));
                    compare_field("flag_c", DATA_W'(want_snap.flags.c),
                                  DATA_W'(got_snap.flags.c));
                    compare_field("flag_v", DATA_W'(want_snap.flags.v),
                                  DATA_W'(got_snap.flags.v));
                end
            end
            // ready pattern: quiet stretches, otherwise random stalls
            if (stall_left != 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else if (cycle_cnt[9:8] == 2'b01) begin
                out_bus.ready <= 1'b1;
            end else begin
                stall_left = rand_gap();
                if (stall_left != 0) begin
                    stall_left--;
                    out_bus.ready <= 1'b0;
                end else begin
                    out_bus.ready <= 1'b1;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned r;
        int unsigned gap;
        logic [KIND_W-1:0] kind;

        rst_n = 1'b0;

        // directed: operand extremes, carry/overflow corners, aliasing
        add_insn(K_MOV,  0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
        add_insn(K_MOV,  1, 0, 0, 32'h8000_0000, 0, 0, 0);
        add_insn(K_MOV,  2, 0, 0, 32'h0000_0001, 0, 0, 0);
        add_insn(K_MOV,  7, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
        add_insn(K_ADDS, 3, 0, 2, '0, 0, 0, 1);   // carry out, masked zero
        add_insn(K_ADDS, 4, 7, 2, '0, 0, 0, 0);   // signed overflow
        add_insn(K_ADDS, 5, 1, 1, '0, 0, 0, 0);   // carry and overflow
        add_insn(K_SUBS, 3, 2, 0, '0, 0, 0, 0);   // borrow
        add_insn(K_SUBS, 4, 1, 2, '0, 0, 0, 0);   // overflow going down
        add_insn(K_CMP,  0, 2, 2, '0, 0, 0, 0);   // equal operands
        add_insn(K_CMP,  0, 7, 1, '0, 0, 0, 0);
        add_insn(K_ADD,  6, 0, 0, '0, 0, 0, 0);
        add_insn(K_SUB,  6, 2, 0, '0, 0, 0, 0);
        add_insn(K_ANDS, 0, 1, 0, '0, 0, 0, 0);   // negative result
        add_insn(K_ORRS, 5, 7, 0, '0, 0, 0, 0);
        add_insn(K_XORS, 2, 2, 0, '0, 0, 0, 0);   // dest is also source
        add_insn(K_TST,  0, 1, 7, '0, 0, 0, 0);
        add_insn(K_LSRS, 3, 1, 0, '0, 31, 0, 0);
        add_insn(K_LSLS, 4, 0, 0, '0, 31, 0, 0);
        add_insn(K_LSL,  5, 7, 0, '0, 0, 0, 0);
        add_insn(K_LSR,  6, 0, 0, '0, 0, 0, 0);
        add_insn(K_AND,  7, 0, 0, '0, 0, 0, 0);
        add_insn(K_ORR,  1, 7, 0, '0, 0, 0, 0);
        add_insn(K_XOR,  6, 0, 0, '0, 0, 0, 0);
        add_insn(K_FIRST_UNUSED, 3, 3, 3, 32'hFFFF_FFFF, 31, 0, 0);  // unused codes
        add_insn(K_LAST_UNUSED,  7, 7, 7, 32'hFFFF_FFFF, 31, 0, 0);
        add_insn(K_ADDS, 3, 3, 3, '0, 0, 0, 0);   // all three the same reg

        // random instruction stream
        for (int i = 0; i < 900; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15) kind = K_MOV;
            else if (r < 95) kind = KIND_W'($urandom_range(K_ADD, K_LSLS));
            else kind = KIND_W'($urandom_range(K_FIRST_UNUSED, K_LAST_UNUSED));
            gap = ((i / 128) % 3 == 1) ? 0 : rand_gap();
            add_insn(kind, $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 7), rand_word(), $urandom_range(0, 31),
                     gap, (i == 300) || (i == 600));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (insn_q.size() != 0) @(posedge clk);
        while (snap_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
